// ===== src/ipv4_receive_header_check_macros.svh =====
// Assertion macros for the IPv4 receive header check.
// Used by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef IPV4_RECEIVE_HEADER_CHECK_MACROS_SVH
`define IPV4_RECEIVE_HEADER_CHECK_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define IPV4RX_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ipv4rx assertion failed");

// Expression must never be true outside reset
`define IPV4RX_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ipv4rx forbidden condition seen");

`else

`define IPV4RX_ASSERT(label, clk, rst_n, prop)
`define IPV4RX_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== src/ipv4rx_pkg.sv =====
// Shared types, constants and helper functions for the IPv4 receive header check.
// No dependencies; imported by every module of the block.
`default_nettype none

package ipv4rx_pkg;

    localparam logic [3:0]  IP_VERSION       = 4'h4;
    localparam int          WORD_SHIFT       = 2;
    localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
    localparam logic [3:0]  MIN_IHL          = 4'd5;
    localparam logic [4:0]  COUNT_LIMIT      = 5'd16;
    localparam logic [15:0] SUM_GOOD         = 16'hFFFF;

    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    // Header word positions that get latched
    localparam logic [4:0] IDX_VER_LEN = 5'd0;
    localparam logic [4:0] IDX_ID_FRAG = 5'd1;
    localparam logic [4:0] IDX_PROTO   = 5'd2;
    localparam logic [4:0] IDX_SOURCE  = 5'd3;
    localparam logic [4:0] IDX_DEST    = 5'd4;

    typedef enum logic [2:0] {
        VERDICT_UDP         = 3'd0,
        VERDICT_TCP         = 3'd1,
        VERDICT_ICMP        = 3'd2,
        VERDICT_MALFORMED   = 3'd3,
        VERDICT_CHECKSUM    = 3'd4,
        VERDICT_NOT_FOR_ME  = 3'd5,
        VERDICT_UNSUPPORTED = 3'd6
    } t_verdict;

    // One incoming header word request
    typedef struct packed {
        logic [31:0] header_word;
        logic        first_word;
        logic        last_word;
        logic [15:0] buffer_bytes;
    } t_word;

    // One verdict request
    typedef struct packed {
        t_verdict    verdict;
        logic        needs_reassembly;
        logic [5:0]  header_bytes;
        logic [15:0] total_length;
        logic [31:0] source_address;
        logic [15:0] identification;
    } t_result;

    // Ones'-complement add with end-around carry; inputs at or below 0xFFFF
    function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, v};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

`default_nettype wire

// ===== src/ipv4rx_word_if.sv =====
// Valid/ready channel carrying header words into the IPv4 receive header check.
// No dependencies.
`default_nettype none

interface ipv4rx_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word;
    logic        first_word;
    logic        last_word;
    logic [15:0] buffer_bytes;

    modport source (output valid, output header_word, output first_word,
                    output last_word, output buffer_bytes, input ready);
    modport sink   (input valid, input header_word, input first_word,
                    input last_word, input buffer_bytes, output ready);
endinterface

`default_nettype wire

// ===== src/ipv4rx_verdict_if.sv =====
// Valid/ready channel carrying verdicts out of the IPv4 receive header check.
// No dependencies.
`default_nettype none

interface ipv4rx_verdict_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic        needs_reassembly;
    logic [5:0]  header_bytes;
    logic [15:0] total_length;
    logic [31:0] source_address;
    logic [15:0] identification;

    modport source (output valid, output verdict, output needs_reassembly,
                    output header_bytes, output total_length,
                    output source_address, output identification, input ready);
    modport sink   (input valid, input verdict, input needs_reassembly,
                    input header_bytes, input total_length,
                    input source_address, input identification, output ready);
endinterface

`default_nettype wire

// ===== src/ipv4_receive_header_check.sv =====
// IPv4 receive header check, top level: input register, header evaluator, verdict register.
// Depends on ipv4rx_pkg, ipv4rx_word_if, ipv4rx_verdict_if, ipv4rx_hdr_eval
// and ipv4_receive_header_check_macros.svh.

// The block takes one 32-bit header word per cycle with no gaps required and
// issues one verdict request for each word marked last. A word passes an input
// register, is folded into the packet state by combinational logic (two 16-bit
// ones'-complement adds plus the verdict compares), and a verdict lands in the
// output register; the verdict for a last word is offered once that word has
// passed the input register and its result is loaded into the output register.
// A waiting verdict does not stop the flow: only a further last word stalls, and
// only while the output register holds a request that is not being taken.
`default_nettype none

`include "ipv4_receive_header_check_macros.svh"

module ipv4_receive_header_check
    import ipv4rx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    ipv4rx_word_if.sink      i_word,
    ipv4rx_verdict_if.source o_result
);

    logic [31:0] r_local_address;
    logic        r_in_valid;
    t_word       r_in;
    logic        r_out_valid;
    t_result     r_out;
    t_result     w_result;
    logic        w_adv;

    // Hold the local address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= '0;
        end else if (i_cfg_we) begin
            r_local_address <= i_cfg_wdata;
        end
    end

    // Advance a word unless it makes a verdict that cannot be placed
    assign w_adv        = r_in_valid && (!r_in.last_word || !r_out_valid || o_result.ready);
    assign i_word.ready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_word.ready) begin
            r_in_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.valid && i_word.ready) begin
            r_in.header_word  <= i_word.header_word;
            r_in.first_word   <= i_word.first_word;
            r_in.last_word    <= i_word.last_word;
            r_in.buffer_bytes <= i_word.buffer_bytes;
        end
    end

    ipv4rx_hdr_eval u_hdr_eval (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_adv),
        .i_item          (r_in),
        .i_local_address (r_local_address),
        .o_result        (w_result)
    );

    // Verdict register: load on a last word, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in.last_word) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in.last_word) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.verdict          = r_out.verdict;
    assign o_result.needs_reassembly = r_out.needs_reassembly;
    assign o_result.header_bytes     = r_out.header_bytes;
    assign o_result.total_length     = r_out.total_length;
    assign o_result.source_address   = r_out.source_address;
    assign o_result.identification   = r_out.identification;

    // A new verdict only follows a processed last word
    `IPV4RX_ASSERT(a_out_from_last, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(w_adv && r_in.last_word))
    // Short headers are always malformed
    `IPV4RX_ASSERT(a_short_hdr_malformed, i_clk, i_rst_n,
        (r_out_valid && r_out.header_bytes < 6'd20) |-> (r_out.verdict == VERDICT_MALFORMED))
    // A checksum verdict implies the length checks passed
    `IPV4RX_ASSERT_NEVER(a_checksum_len, i_clk, i_rst_n,
        r_out_valid && r_out.verdict == VERDICT_CHECKSUM && r_out.total_length < MIN_HEADER_BYTES)

endmodule

`default_nettype wire

// ===== src/ipv4rx_hdr_eval.sv =====
// Per-packet header state (field latches, running checksum, word count) and verdict logic.
// Depends on ipv4rx_pkg.
`default_nettype none

module ipv4rx_hdr_eval
    import ipv4rx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire t_word       i_item,
    input  wire logic [31:0] i_local_address,
    output t_result          o_result
);

    logic [4:0]  r_word_count;
    logic [15:0] r_sum;
    logic [15:0] r_length;
    logic [31:0] r_first_hdr;
    logic [31:0] r_id_frag;
    logic [7:0]  r_protocol;
    logic [31:0] r_source;
    logic [31:0] r_dest;

    logic [4:0]  n_word_count;
    logic [15:0] n_sum;
    logic [15:0] n_length;
    logic [31:0] n_first_hdr;
    logic [31:0] n_id_frag;
    logic [7:0]  n_protocol;
    logic [31:0] n_source;
    logic [31:0] n_dest;

    logic [4:0]  w_idx;
    logic [15:0] w_sum_base;
    logic [15:0] w_sum_hi;
    logic [3:0]  w_ihl;
    logic [15:0] w_hdr_bytes;
    logic [15:0] w_tlen;
    logic        w_malformed;
    t_verdict    w_verdict;

    // Start from cleared state on the first word, else continue the packet
    always_comb begin
        n_length    = i_item.first_word ? i_item.buffer_bytes : r_length;
        n_first_hdr = i_item.first_word ? 32'd0 : r_first_hdr;
        n_id_frag   = i_item.first_word ? 32'd0 : r_id_frag;
        n_protocol  = i_item.first_word ? 8'd0  : r_protocol;
        n_source    = i_item.first_word ? 32'd0 : r_source;
        n_dest      = i_item.first_word ? 32'd0 : r_dest;
        w_sum_base  = i_item.first_word ? 16'd0 : r_sum;
        w_idx       = i_item.first_word ? 5'd0  : r_word_count;

        // Latch the field words by position
        unique case (w_idx)
            IDX_VER_LEN: n_first_hdr = i_item.header_word;
            IDX_ID_FRAG: n_id_frag   = i_item.header_word;
            IDX_PROTO:   n_protocol  = i_item.header_word[23:16];
            IDX_SOURCE:  n_source    = i_item.header_word;
            IDX_DEST:    n_dest      = i_item.header_word;
            default: ;
        endcase

        // Sum both halves of words inside the header length
        w_ihl    = n_first_hdr[27:24];
        w_sum_hi = fold_add(w_sum_base, i_item.header_word[31:16]);
        if (w_idx < {1'b0, w_ihl}) begin
            n_sum = fold_add(w_sum_hi, i_item.header_word[15:0]);
        end else begin
            n_sum = w_sum_base;
        end

        // Count words, saturating
        n_word_count = (w_idx < COUNT_LIMIT) ? (w_idx + 5'd1) : w_idx;
    end

    // Verdict in priority order
    always_comb begin
        w_hdr_bytes = {10'd0, w_ihl, 2'b00};
        w_tlen      = n_first_hdr[15:0];
        w_malformed = (n_length < MIN_HEADER_BYTES) ||
                      (n_first_hdr[31:28] != IP_VERSION) ||
                      (w_tlen < MIN_HEADER_BYTES) ||
                      (w_ihl < MIN_IHL) ||
                      (n_length < w_hdr_bytes) ||
                      (n_word_count < {1'b0, w_ihl});
        if (w_malformed) begin
            w_verdict = VERDICT_MALFORMED;
        end else if (n_sum != SUM_GOOD) begin
            w_verdict = VERDICT_CHECKSUM;
        end else if (n_dest != i_local_address) begin
            w_verdict = VERDICT_NOT_FOR_ME;
        end else begin
            case (n_protocol)
                PROTO_UDP:  w_verdict = VERDICT_UDP;
                PROTO_TCP:  w_verdict = VERDICT_TCP;
                PROTO_ICMP: w_verdict = VERDICT_ICMP;
                default:    w_verdict = VERDICT_UNSUPPORTED;
            endcase
        end

        o_result.verdict          = w_verdict;
        o_result.needs_reassembly = n_id_frag[13] || (n_id_frag[12:0] != 13'd0);
        o_result.header_bytes     = w_hdr_bytes[5:0];
        o_result.total_length     = w_tlen;
        o_result.source_address   = n_source;
        o_result.identification   = n_id_frag[31:16];
    end

    // Advance packet state on each processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count <= '0;
            r_sum        <= '0;
            r_length     <= '0;
            r_first_hdr  <= '0;
            r_id_frag    <= '0;
            r_protocol   <= '0;
            r_source     <= '0;
            r_dest       <= '0;
        end else if (i_step) begin
            r_word_count <= n_word_count;
            r_sum        <= n_sum;
            r_length     <= n_length;
            r_first_hdr  <= n_first_hdr;
            r_id_frag    <= n_id_frag;
            r_protocol   <= n_protocol;
            r_source     <= n_source;
            r_dest       <= n_dest;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_ipv4_receive_header_check.sv =====
// Testbench for ipv4_receive_header_check: drives header word requests, predicts
// each verdict request and compares it field by field with what the block returns.
// Depends on ipv4rx_pkg, ipv4rx_word_if, ipv4rx_verdict_if and the RTL top level.

module tb_ipv4_receive_header_check;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4rx_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED = 100;

    localparam t_result NO_RESULT = '{VERDICT_UDP, 1'b0, 6'd0, 16'd0, 32'd0, 16'd0};

    // One row of the directed table: a word, and a hand-written verdict where one is given
    typedef struct packed {
        t_word   w;
        logic    typed;
        t_result want;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [31:0] i_cfg_wdata;

    ipv4rx_word_if    word_ch();
    ipv4rx_verdict_if verdict_ch();

    ipv4_receive_header_check u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_word     (word_ch),
        .o_result   (verdict_ch)
    );

    // Packet state mirrored by the predictor
    logic [4:0]  p_count;
    logic [16:0] p_sum;
    logic [15:0] p_len;
    logic [31:0] p_w0;
    logic [31:0] p_w1;
    logic [7:0]  p_proto;
    logic [31:0] p_src;
    logic [31:0] p_dst;
    logic [31:0] local_addr;

    t_result pending_verdicts[$];
    t_word   packet_words[$];

    int cycle_count;
    int mismatches;
    int sent_words;
    int idle_pct;
    int stall_pct;
    bit hold_request;
    bit hold_off;

    stim_row_t directed_rows [26] = '{
        // single word with both marks right after reset
        '{'{32'h0000_0000, 1'b1, 1'b1, 16'd0}, 1'b1,
          '{VERDICT_MALFORMED, 1'b0, 6'd0, 16'd0, 32'd0, 16'd0}},
        // all ones: version 15, longest header
        '{'{32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF}, 1'b1,
          '{VERDICT_MALFORMED, 1'b0, 6'd60, 16'hFFFF, 32'd0, 16'd0}},
        // clean UDP to address zero
        '{'{32'h4500_0014, 1'b1, 1'b0, 16'd20}, 1'b0, NO_RESULT},
        '{'{32'h0000_0000, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h4011_70D9, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h0A00_0001, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h0000_0000, 1'b0, 1'b1, 16'd0}, 1'b1,
          '{VERDICT_UDP, 1'b0, 6'd20, 16'd20, 32'h0A00_0001, 16'd0}},
        // ICMP with more-fragments set
        '{'{32'h4500_0014, 1'b1, 1'b0, 16'd20}, 1'b0, NO_RESULT},
        '{'{32'h1234_2000, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h4001_3EB5, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h0A00_0001, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h0000_0000, 1'b0, 1'b1, 16'd0}, 1'b0, NO_RESULT},
        // TCP with a zero checksum field
        '{'{32'h4500_0014, 1'b1, 1'b0, 16'd24}, 1'b0, NO_RESULT},
        '{'{32'h0000_0000, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h4006_0000, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h0A00_0001, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h0000_0000, 1'b0, 1'b1, 16'd0}, 1'b1,
          '{VERDICT_CHECKSUM, 1'b0, 6'd20, 16'd20, 32'h0A00_0001, 16'd0}},
        // six-word header cut short after three words
        '{'{32'h4600_0018, 1'b1, 1'b0, 16'd24}, 1'b0, NO_RESULT},
        '{'{32'hABCD_1FFF, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h0000_0000, 1'b0, 1'b1, 16'd0}, 1'b1,
          '{VERDICT_MALFORMED, 1'b1, 6'd24, 16'h0018, 32'd0, 16'hABCD}},
        // continue the same packet without a first mark
        '{'{32'hC0A8_0001, 1'b0, 1'b1, 16'd0}, 1'b1,
          '{VERDICT_MALFORMED, 1'b1, 6'd24, 16'h0018, 32'hC0A8_0001, 16'hABCD}},
        // unsupported protocol, good checksum
        '{'{32'h4500_0014, 1'b1, 1'b0, 16'd20}, 1'b0, NO_RESULT},
        '{'{32'h0000_0000, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h40FF_6FEB, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h0A00_0001, 1'b0, 1'b0, 16'd0}, 1'b0, NO_RESULT},
        '{'{32'h0000_0000, 1'b0, 1'b1, 16'd0}, 1'b0, NO_RESULT}
    };

    // Ones'-complement add with end-around carry, sum kept at or below 0xFFFF
    function automatic logic [16:0] ones_add(input logic [16:0] acc, input logic [15:0] v);
        logic [16:0] t;
        t = acc + {1'b0, v};
        return {1'b0, t[15:0]} + {16'd0, t[16]};
    endfunction

    // Fold one accepted word into the packet state; give the verdict on a last word
    task automatic predict_verdict(input t_word w, output bit produced, output t_result r);
        logic [4:0]  idx;
        logic [3:0]  ihl;
        logic [15:0] tlen;
        logic [15:0] frag_word;
        t_verdict    v;
        r = NO_RESULT;
        if (w.first_word) begin
            p_count = '0;
            p_sum   = '0;
            p_w0    = '0;
            p_w1    = '0;
            p_proto = '0;
            p_src   = '0;
            p_dst   = '0;
            p_len   = w.buffer_bytes;
        end
        idx = p_count;
        case (idx)
            IDX_VER_LEN: begin
                p_w0 = w.header_word;
            end
            IDX_ID_FRAG: begin
                p_w1 = w.header_word;
            end
            IDX_PROTO: begin
                p_proto = w.header_word[23:16];
            end
            IDX_SOURCE: begin
                p_src = w.header_word;
            end
            IDX_DEST: begin
                p_dst = w.header_word;
            end
            default: begin
            end
        endcase
        ihl = p_w0[27:24];
        if (idx < {1'b0, ihl}) begin
            p_sum = ones_add(ones_add(p_sum, w.header_word[31:16]), w.header_word[15:0]);
        end
        if (p_count < COUNT_LIMIT) begin
            p_count = p_count + 5'd1;
        end
        produced = w.last_word;
        if (!produced) begin
            return;
        end
        tlen = p_w0[15:0];
        frag_word = p_w1[15:0];
        if (p_len < MIN_HEADER_BYTES || p_w0[31:28] != IP_VERSION ||
            tlen < MIN_HEADER_BYTES || ihl < MIN_IHL ||
            p_len < {10'd0, ihl, 2'b00} || p_count < {1'b0, ihl}) begin
            v = VERDICT_MALFORMED;
        end else if (p_sum != {1'b0, SUM_GOOD}) begin
            v = VERDICT_CHECKSUM;
        end else if (p_dst != local_addr) begin
            v = VERDICT_NOT_FOR_ME;
        end else if (p_proto == PROTO_UDP) begin
            v = VERDICT_UDP;
        end else if (p_proto == PROTO_TCP) begin
            v = VERDICT_TCP;
        end else if (p_proto == PROTO_ICMP) begin
            v = VERDICT_ICMP;
        end else begin
            v = VERDICT_UNSUPPORTED;
        end
        r.verdict          = v;
        r.needs_reassembly = frag_word[13] || (frag_word[12:0] != 13'd0);
        r.header_bytes     = {ihl, 2'b00};
        r.total_length     = tlen;
        r.source_address   = p_src;
        r.identification   = p_w1[31:16];
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTED) begin
            $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h",
                     $time, field, got, want);
        end
        mismatches++;
    endtask

    // Offer one word request, wait for acceptance, then record what it should produce
    task automatic send_word(input t_word w, input bit typed, input t_result want);
        bit      produced;
        t_result predicted;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            word_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        word_ch.valid        <= 1'b1;
        word_ch.header_word  <= w.header_word;
        word_ch.first_word   <= w.first_word;
        word_ch.last_word    <= w.last_word;
        word_ch.buffer_bytes <= w.buffer_bytes;
        do @(posedge i_clk); while (!word_ch.ready);
        predict_verdict(w, produced, predicted);
        if (produced) begin
            pending_verdicts.push_back(typed ? want : predicted);
        end
        sent_words++;
    endtask

    // Build one packet: mostly well-formed with random content, some broken, some noise
    task automatic build_packet();
        logic [31:0] hdr [16];
        logic [16:0] acc;
        logic [15:0] bytes;
        logic [7:0]  proto;
        t_word       w;
        int          ihl;
        int          n_words;
        int          bit_sel;
        bit          no_first;
        packet_words.delete();
        if ($urandom_range(99) < 15) begin
            n_words = $urandom_range(6, 1);
            for (int i = 0; i < n_words; i++) begin
                w.header_word  = $urandom;
                w.first_word   = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(9) == 0);
                w.last_word    = (i == n_words - 1) ? ($urandom_range(3) != 0)
                                                    : ($urandom_range(9) == 0);
                w.buffer_bytes = 16'($urandom);
                packet_words.push_back(w);
            end
            return;
        end
        ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
        case ($urandom_range(3))
            0: proto = PROTO_UDP;
            1: proto = PROTO_TCP;
            2: proto = PROTO_ICMP;
            default: proto = 8'($urandom);
        endcase
        hdr[0] = {IP_VERSION, 4'(ihl), 8'($urandom), 16'($urandom_range(65535, 20))};
        hdr[1] = {16'($urandom), ($urandom_range(1) != 0) ? 16'h0000 : 16'($urandom)};
        hdr[2] = {8'($urandom), proto, 16'h0000};
        hdr[3] = $urandom;
        hdr[4] = ($urandom_range(9) < 8) ? local_addr : $urandom;
        for (int i = 5; i < ihl; i++) begin
            hdr[i] = $urandom;
        end
        acc = '0;
        for (int i = 0; i < ihl; i++) begin
            acc = ones_add(ones_add(acc, hdr[i][31:16]), hdr[i][15:0]);
        end
        hdr[2][15:0] = ~acc[15:0];
        n_words = ihl + (($urandom_range(7) == 0) ? $urandom_range(14, 4) : $urandom_range(2, 0));
        bytes = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(n_words * 4);
        no_first = 1'b0;
        // break the packet in one way now and then
        case ($urandom_range(19))
            0: begin
                bit_sel = $urandom_range(15);
                hdr[2][bit_sel] = ~hdr[2][bit_sel];
            end
            1: hdr[0][31:28] = 4'($urandom);
            2: hdr[0][27:24] = 4'($urandom_range(4));
            3: n_words = $urandom_range(ihl - 1, 1);
            4: bytes = 16'($urandom_range(ihl * 4 - 1, 0));
            5: no_first = 1'b1;
            6: hdr[0][15:0] = 16'($urandom_range(19));
            default: begin
            end
        endcase
        for (int i = 0; i < n_words; i++) begin
            w.header_word  = (i < ihl) ? hdr[i] : $urandom;
            w.first_word   = (i == 0) && !no_first;
            w.last_word    = (i == n_words - 1);
            w.buffer_bytes = (i == 0) ? bytes : 16'($urandom);
            packet_words.push_back(w);
        end
    endtask

    task automatic drain();
        while (pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write the local address once the block has gone quiet
    task automatic write_local_address(input logic [31:0] addr);
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= addr;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        local_addr = addr;
    endtask

    task automatic run_phase(input int n_items, input int send_idle, input int recv_stall,
                             input bit pressure);
        int start;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        start     = sent_words;
        if (pressure) begin
            hold_request = 1'b1;
        end
        while (sent_words - start < n_items) begin
            build_packet();
            foreach (packet_words[i]) begin
                send_word(packet_words[i], 1'b0, NO_RESULT);
            end
        end
        @(negedge i_clk);
        word_ch.valid <= 1'b0;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** ipv4_receive_header_check: FAILED **");
            $finish;
        end
    end

    // Receiver: drop ready at random, and hold it off entirely while a hold-off runs
    initial begin
        verdict_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            verdict_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial begin
        hold_off = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
                hold_request = 1'b0;
            end
        end
    end

    // Compare each accepted verdict request with the oldest pending one
    always @(posedge i_clk) begin : check_verdicts
        t_result want;
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected verdict", 32'(verdict_ch.verdict), 32'd0);
            end else begin
                want = pending_verdicts.pop_front();
                if (verdict_ch.verdict !== want.verdict)
                    report_mismatch("verdict", 32'(verdict_ch.verdict), 32'(want.verdict));
                if (verdict_ch.needs_reassembly !== want.needs_reassembly)
                    report_mismatch("needs_reassembly", 32'(verdict_ch.needs_reassembly),
                                    32'(want.needs_reassembly));
                if (verdict_ch.header_bytes !== want.header_bytes)
                    report_mismatch("header_bytes", 32'(verdict_ch.header_bytes),
                                    32'(want.header_bytes));
                if (verdict_ch.total_length !== want.total_length)
                    report_mismatch("total_length", 32'(verdict_ch.total_length),
                                    32'(want.total_length));
                if (verdict_ch.source_address !== want.source_address)
                    report_mismatch("source_address", verdict_ch.source_address,
                                    want.source_address);
                if (verdict_ch.identification !== want.identification)
                    report_mismatch("identification", 32'(verdict_ch.identification),
                                    32'(want.identification));
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        word_ch.valid        = 1'b0;
        word_ch.header_word  = '0;
        word_ch.first_word   = 1'b0;
        word_ch.last_word    = 1'b0;
        word_ch.buffer_bytes = '0;
        mismatches   = 0;
        sent_words   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 1'b0;
        local_addr   = '0;
        p_count = '0;
        p_sum   = '0;
        p_len   = '0;
        p_w0    = '0;
        p_w1    = '0;
        p_proto = '0;
        p_src   = '0;
        p_dst   = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, no idling
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);
        end
        @(negedge i_clk);
        word_ch.valid <= 1'b0;

        // Random phases, each under its own local address
        write_local_address($urandom);
        run_phase(110, 0, 0, 1'b0);
        write_local_address(32'hFFFF_FFFF);
        run_phase(110, 73, 0, 1'b0);
        write_local_address(32'h0000_0000);
        run_phase(110, 0, 73, 1'b0);
        write_local_address($urandom);
        run_phase(110, 38, 38, 1'b0);
        write_local_address($urandom);
        run_phase(60, 0, 0, 1'b1);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            report_mismatch("verdicts never returned", 32'(pending_verdicts.size()), 32'd0);
        end
        if (mismatches == 0) begin
            $display("** ipv4_receive_header_check: PASSED **");
        end else begin
            $display("** ipv4_receive_header_check: FAILED **");
        end
        $finish;
    end

endmodule
